@@ hdl/ssid_pkg.sv @@
package ssid_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READOUT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ELEMENT   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [KEY_W-1:0] key_value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] element;
        logic                    last;
        logic [OCC_W-1:0]        occupancy;
    } result_t;

endpackage

@@ hdl/ssid_stream_if.sv @@
interface ssid_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/ssid_ram.sv @@
module ssid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // hold read data while no read is issued
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ hdl/sorted_set_insert_delete_unit.sv @@
// Sorted set of up to CAPACITY distinct signed values, kept ascending in one
// single-port-read, single-port-write RAM. An insert or delete walks the
// stored entries from the bottom, one entry per cycle through the RAM read
// port, and shifts the entries above the hit position by one place in the
// same pass; with N values stored its steps are accept, N reads, the RAM
// read latency, and posting the result. A readout emits one item per cycle,
// slowed by any stall on the result side. Operations on an empty set skip
// the walk. Command 3 is dropped with no result. A new item is taken while
// the last result still waits in the output register. Keys are reduced to
// VALUE_WIDTH bits and compared as two's complement numbers.
module sorted_set_insert_delete_unit #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    ssid_stream_if.sink   request,
    ssid_stream_if.source result
);
    import ssid_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // sign extend a stored value and cut it to the 32-bit result field
    function automatic logic [KEY_W-1:0] to_field(input logic [VALUE_WIDTH-1:0] v);
        logic signed [63:0] w;
        begin
            w = 64'(signed'(v));
            return w[KEY_W-1:0];
        end
    endfunction

    // control state
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pend_reg, pend_next;
    logic          hit_reg, hit_next;
    logic          res_valid_reg, res_valid_next;

    // per-item working registers
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [KEY_W-1:0]       elem_reg, elem_next;
    logic [VALUE_WIDTH-1:0] carry_reg, carry_next;
    logic [STATUS_W-1:0]    code_reg, code_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic [AW-1:0]          ev_idx_reg, ev_idx_next;
    result_t                res_data_reg, res_data_next;

    // RAM port signals
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;

    logic                   slot_free;
    logic                   last_ev;
    logic                   e_eq;
    logic                   e_gt;
    logic                   stall;
    logic [VALUE_WIDTH-1:0] key_red;
    logic [CW-1:0]          count_fin;

    ssid_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign request.ready = (state_reg == S_IDLE);
    assign result.valid  = res_valid_reg;
    assign result.data   = res_data_reg;

    // the output register may be refilled when empty or being drained
    assign slot_free = !res_valid_reg || result.ready;
    // the entry under evaluation is the top stored one
    assign last_ev   = (CW'(ev_idx_reg) == (count_reg - CW'(1)));
    assign e_eq      = (rd_data == key_reg);
    assign e_gt      = ($signed(rd_data) > $signed(key_reg));
    assign stall     = (cmd_reg == CMD_READOUT) && pend_reg && !slot_free;
    // wrap the 32-bit key to VALUE_WIDTH bits
    assign key_red   = VALUE_WIDTH'(64'(signed'(request.data.key_value)));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        res_valid_next = res_valid_reg && !result.ready;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        elem_next      = elem_reg;
        carry_next     = carry_reg;
        code_next      = code_reg;
        rd_idx_next    = rd_idx_reg;
        ev_idx_next    = ev_idx_reg;
        res_data_next  = res_data_reg;
        wr_en          = 1'b0;
        wr_addr        = ev_idx_reg;
        wr_data        = key_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg[AW-1:0];
        count_fin      = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    cmd_next    = request.data.command;
                    key_next    = key_red;
                    elem_next   = to_field(key_red);
                    hit_next    = 1'b0;
                    pend_next   = 1'b0;
                    rd_idx_next = '0;
                    case (request.data.command)
                        CMD_INSERT:
                        begin
                            // empty set: place the key at the bottom directly
                            if (count_reg == '0)
                            begin
                                code_next  = ST_INSERTED;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                code_next  = ST_EMPTY;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        CMD_READOUT:
                        begin
                            if (count_reg == '0)
                            begin
                                code_next  = ST_EMPTY;
                                elem_next  = '0;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        default:
                        begin
                            // unused command: drop the item
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                if (!stall)
                begin
                    // issue the next read one entry ahead of evaluation
                    if (rd_idx_reg < count_reg)
                    begin
                        rd_en       = 1'b1;
                        rd_idx_next = rd_idx_reg + CW'(1);
                        ev_idx_next = rd_idx_reg[AW-1:0];
                        pend_next   = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end

                    if (pend_reg)
                    begin
                        case (cmd_reg)
                            CMD_INSERT:
                            begin
                                if (!hit_reg)
                                begin
                                    if (e_eq)
                                    begin
                                        code_next  = ST_DUPLICATE;
                                        state_next = S_FINISH;
                                    end
                                    else if (e_gt)
                                    begin
                                        // first larger entry: key goes here
                                        if (count_reg == CAP_C)
                                        begin
                                            code_next  = ST_FULL;
                                            state_next = S_FINISH;
                                        end
                                        else
                                        begin
                                            wr_en      = 1'b1;
                                            wr_data    = key_reg;
                                            hit_next   = 1'b1;
                                            carry_next = rd_data;
                                            if (last_ev)
                                            begin
                                                code_next  = ST_INSERTED;
                                                state_next = S_FINISH;
                                            end
                                        end
                                    end
                                    else if (last_ev)
                                    begin
                                        // key is above every stored value
                                        code_next  = (count_reg == CAP_C) ? ST_FULL
                                                                           : ST_INSERTED;
                                        state_next = S_FINISH;
                                    end
                                end
                                else
                                begin
                                    // shift up: write the carried entry, carry this one
                                    wr_en      = 1'b1;
                                    wr_data    = carry_reg;
                                    carry_next = rd_data;
                                    if (last_ev)
                                    begin
                                        code_next  = ST_INSERTED;
                                        state_next = S_FINISH;
                                    end
                                end
                            end
                            CMD_DELETE:
                            begin
                                if (!hit_reg)
                                begin
                                    if (e_eq)
                                    begin
                                        hit_next = 1'b1;
                                    end
                                    if (last_ev)
                                    begin
                                        code_next  = e_eq ? ST_DELETED : ST_NOT_FOUND;
                                        state_next = S_FINISH;
                                    end
                                end
                                else
                                begin
                                    // shift down over the removed entry
                                    wr_en   = 1'b1;
                                    wr_addr = ev_idx_reg - AW'(1);
                                    wr_data = rd_data;
                                    if (last_ev)
                                    begin
                                        code_next  = ST_DELETED;
                                        state_next = S_FINISH;
                                    end
                                end
                            end
                            CMD_READOUT:
                            begin
                                res_valid_next          = 1'b1;
                                res_data_next.status    = ST_ELEMENT;
                                res_data_next.element   = to_field(rd_data);
                                res_data_next.last      = last_ev;
                                res_data_next.occupancy = OCC_W'(count_reg);
                                if (last_ev)
                                begin
                                    state_next = S_IDLE;
                                end
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_FINISH:
            begin
                if (slot_free)
                begin
                    if ((cmd_reg == CMD_INSERT) && (code_reg == ST_INSERTED))
                    begin
                        // top slot gets the carried entry, or the key if none moved
                        wr_en     = 1'b1;
                        wr_addr   = count_reg[AW-1:0];
                        wr_data   = hit_reg ? carry_reg : key_reg;
                        count_fin = count_reg + CW'(1);
                    end
                    else if ((cmd_reg == CMD_DELETE) && (code_reg == ST_DELETED))
                    begin
                        count_fin = count_reg - CW'(1);
                    end
                    count_next              = count_fin;
                    res_valid_next          = 1'b1;
                    res_data_next.status    = code_reg;
                    res_data_next.element   = elem_reg;
                    res_data_next.last      = 1'b1;
                    res_data_next.occupancy = OCC_W'(count_fin);
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        elem_reg     <= elem_next;
        carry_reg    <= carry_next;
        code_reg     <= code_next;
        rd_idx_reg   <= rd_idx_next;
        ev_idx_reg   <= ev_idx_next;
        res_data_reg <= res_data_next;
    end
endmodule

@@ hdl/ssid_checker.sv @@
module ssid_checker #(
    parameter int CAPACITY = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [ssid_pkg::STATUS_W-1:0] res_status,
    input logic [ssid_pkg::KEY_W-1:0]    res_element,
    input logic                          res_last,
    input logic [ssid_pkg::OCC_W-1:0]    res_occupancy
);
    import ssid_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid
            && $stable({res_status, res_element, res_last, res_occupancy}))
        else $error("stalled result changed");

    // only readout items may leave the sequence open
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status != ST_ELEMENT) |-> res_last)
        else $error("single result without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_EMPTY) |-> (res_occupancy == '0))
        else $error("empty status with stored values");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_FULL) && (CAPACITY <= 31)
            |-> (res_occupancy == OCC_W'(CAPACITY)))
        else $error("full drop below capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_INSERTED) && (CAPACITY <= 31)
            |-> (res_occupancy != '0))
        else $error("insert left the set empty");
endmodule

bind sorted_set_insert_delete_unit ssid_checker #(
    .CAPACITY (CAPACITY)
) u_ssid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_status    (result.data.status),
    .res_element   (result.data.element),
    .res_last      (result.data.last),
    .res_occupancy (result.data.occupancy)
);
